FILE: sv/wakeup_interrupt_unit_defines.svh
// Assertion macros for the wakeup interrupt unit checker.
// No dependencies; included by wkup_checker.sv.
`ifndef WAKEUP_INTERRUPT_UNIT_DEFINES_SVH
`define WAKEUP_INTERRUPT_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define WKUP_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define WKUP_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/wkup_pkg.sv
// Shared types and constants for the wakeup interrupt unit.
// No dependencies; imported by wkup_ctrl_store, wkup_state, the top level and the testbench.
package wkup_pkg;

    localparam int NUM_LINES_DEF  = 16;
    localparam int FLAG_BYTES_DEF = 2;

    localparam logic [7:0] MASK_RST_DEF = 8'hFF;
    localparam logic [7:0] MASK_RST_B1  = 8'hC0;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2
    } wkup_act_t;

    typedef struct packed {
        logic launch;
        logic bad_addr;
        logic ctrl_rd;
        logic ctrl_wr;
    } wkup_stat_t;

endpackage

FILE: sv/wkup_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wkup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/wkup_ctrl_store.sv
// Per-line control registers: RAM plus written-bits and write-to-read bypass.
// Depends on wkup_pkg and wkup_ram.
module wkup_ctrl_store
    import wkup_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_LINES)-1:0] wr_idx,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_LINES)-1:0] rd_idx,
    output logic [7:0]                   rd_data
);

    logic [NUM_LINES-1:0] vld_reg;
    logic                 rd_vld_reg;
    logic                 fwd_reg;
    logic [7:0]           fwd_data_reg;
    logic [7:0]           ram_q;

    wkup_ram #(
        .WIDTH (8),
        .DEPTH (NUM_LINES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
                fwd_reg    <= wr_en && (wr_idx == rd_idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // unwritten entries read as zero
    assign rd_data = fwd_reg    ? fwd_data_reg :
                     rd_vld_reg ? ram_q        : 8'h00;

endmodule

FILE: sv/wkup_state.sv
// Mask, flag and level-history registers with address decode, edge
// detection and lowest-line-first scan. Depends on wkup_pkg.
module wkup_state
    import wkup_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int FLAG_BYTES = FLAG_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [1:0]                   action,
    input  logic [4:0]                   reg_addr,
    input  logic [7:0]                   write_data,
    input  logic [15:0]                  irq_levels,
    input  logic                         seq_busy,
    output wkup_stat_t                   stat,
    output logic [7:0]                   rd_byte,
    output logic [$clog2(NUM_LINES)-1:0] ctrl_idx,
    output logic [$clog2(NUM_LINES)-1:0] line
);

    localparam int FLAG_BITS = 8 * FLAG_BYTES;
    localparam int EFF       = (NUM_LINES < FLAG_BITS) ? NUM_LINES : FLAG_BITS;
    localparam int LVL_W     = (NUM_LINES < 16) ? NUM_LINES : 16;
    localparam int REG_END   = 2 * FLAG_BYTES + NUM_LINES;
    localparam int AW_MIN    = $clog2(REG_END + 1);
    localparam int AW        = (AW_MIN > 5) ? AW_MIN : 5;
    localparam int FB_W      = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;
    localparam int LINE_W    = $clog2(NUM_LINES);
    localparam logic [FLAG_BITS-1:0] EFF_MASK = {FLAG_BITS{1'b1}} >> (FLAG_BITS - EFF);

    logic [FLAG_BITS-1:0] mask_reg, mask_next;
    logic [FLAG_BITS-1:0] flag_reg, flag_next;
    logic [LVL_W-1:0]     prev_reg, prev_next;

    logic [AW-1:0]        addr_x;
    logic                 hit_mask, hit_flag, hit_ctrl;
    logic [FB_W-1:0]      midx, fidx;
    logic                 is_rd, is_wr, is_smp;
    logic [LVL_W-1:0]     lvl;
    logic [FLAG_BITS-1:0] rise_x;
    logic [FLAG_BITS-1:0] live;
    logic                 found;
    logic [7:0]           sel_byte;

    assign addr_x   = AW'(reg_addr);
    assign hit_mask = addr_x < AW'(FLAG_BYTES);
    assign hit_flag = !hit_mask && (addr_x < AW'(2 * FLAG_BYTES));
    assign hit_ctrl = !hit_mask && !hit_flag && (addr_x < AW'(REG_END));
    assign midx     = FB_W'(addr_x);
    assign fidx     = FB_W'(addr_x - AW'(FLAG_BYTES));
    assign ctrl_idx = LINE_W'(addr_x - AW'(2 * FLAG_BYTES));
    assign lvl      = irq_levels[LVL_W-1:0];
    assign rise_x   = FLAG_BITS'(lvl & ~prev_reg);

    always_comb
    begin
        is_rd  = 1'b0;
        is_wr  = 1'b0;
        is_smp = 1'b0;
        case (wkup_act_t'(action))
            ACT_READ:   is_rd  = 1'b1;
            ACT_WRITE:  is_wr  = 1'b1;
            ACT_SAMPLE: is_smp = 1'b1;
            default:    ;
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        flag_next = flag_reg;
        prev_next = prev_reg;
        sel_byte  = 8'h00;
        for (int b = 0; b < FLAG_BYTES; b++)
        begin
            if (hit_mask && FB_W'(b) == midx)
            begin
                sel_byte = mask_reg[b*8 +: 8];
                if (is_wr)
                begin
                    mask_next[b*8 +: 8] = write_data;
                end
            end
            if (hit_flag && FB_W'(b) == fidx)
            begin
                sel_byte = flag_reg[b*8 +: 8];
                if (is_wr)
                begin
                    flag_next[b*8 +: 8] = write_data;
                end
            end
        end
        if (is_smp)
        begin
            prev_next = lvl;
            flag_next = flag_reg | (rise_x & EFF_MASK);
        end
    end

    // lowest live line wins
    assign live = flag_next & ~mask_next & EFF_MASK;

    always_comb
    begin
        found = 1'b0;
        line  = '0;
        for (int i = FLAG_BITS - 1; i >= 0; i--)
        begin
            if (live[i])
            begin
                found = 1'b1;
                line  = LINE_W'(i);
            end
        end
    end

    always_comb
    begin
        stat.ctrl_rd  = is_rd && hit_ctrl;
        stat.ctrl_wr  = is_wr && hit_ctrl;
        stat.bad_addr = (is_rd || is_wr) && !hit_mask && !hit_flag && !hit_ctrl;
        stat.launch   = found && !seq_busy &&
                        (is_smp || (is_wr && (hit_mask || hit_flag || hit_ctrl)));
        rd_byte       = is_rd ? sel_byte : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
            prev_reg <= '0;
            for (int b = 0; b < FLAG_BYTES; b++)
            begin
                mask_reg[b*8 +: 8] <= (b == 1) ? MASK_RST_B1 : MASK_RST_DEF;
            end
        end
        else if (en)
        begin
            mask_reg <= mask_next;
            flag_reg <= flag_next;
            prev_reg <= prev_next;
        end
    end

endmodule

FILE: sv/wakeup_interrupt_unit.sv
// Each request passes the input register, then the result register and
// control RAM read register.
// Throughput: one request per cycle; in_ready stays high while the result
// register is free or being taken. Reset clears masks to 0xFF/0xC0, flags,
// level history and control registers (via written bits), and both valids.
// Top level of the wakeup interrupt unit. Depends on wkup_pkg, wkup_state
// and wkup_ctrl_store.
module wakeup_interrupt_unit
    import wkup_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int FLAG_BYTES = FLAG_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [4:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic [15:0] irq_levels,
    input  logic        seq_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        launch,
    output logic [7:0]  launch_seq,
    output logic [3:0]  launch_line,
    output logic        bad_addr
);

    localparam int LINE_W = $clog2(NUM_LINES);

    logic              s1_valid_reg;
    logic [1:0]        action_reg;
    logic [4:0]        addr_reg;
    logic [7:0]        wdata_reg;
    logic [15:0]       levels_reg;
    logic              busy_reg;

    logic              out_valid_reg;
    logic              launch_reg;
    logic              bad_reg;
    logic              ctrl_rd_reg;
    logic [7:0]        rd_reg;
    logic [LINE_W-1:0] line_reg;

    logic              out_free;
    logic              advance;
    wkup_stat_t        stat;
    logic [7:0]        rd_byte;
    logic [LINE_W-1:0] ctrl_idx;
    logic [LINE_W-1:0] line;
    logic [7:0]        ctrl_q;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    wkup_state #(
        .NUM_LINES  (NUM_LINES),
        .FLAG_BYTES (FLAG_BYTES)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .action     (action_reg),
        .reg_addr   (addr_reg),
        .write_data (wdata_reg),
        .irq_levels (levels_reg),
        .seq_busy   (busy_reg),
        .stat       (stat),
        .rd_byte    (rd_byte),
        .ctrl_idx   (ctrl_idx),
        .line       (line)
    );

    wkup_ctrl_store #(
        .NUM_LINES (NUM_LINES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance && stat.ctrl_wr),
        .wr_idx  (ctrl_idx),
        .wr_data (wdata_reg),
        .rd_en   (advance && (stat.ctrl_rd || stat.launch)),
        .rd_idx  (stat.ctrl_rd ? ctrl_idx : line),
        .rd_data (ctrl_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            launch_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            ctrl_rd_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                launch_reg    <= stat.launch;
                bad_reg       <= stat.bad_addr;
                ctrl_rd_reg   <= stat.ctrl_rd;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            addr_reg   <= reg_addr;
            wdata_reg  <= write_data;
            levels_reg <= irq_levels;
            busy_reg   <= seq_busy;
        end
        if (advance)
        begin
            rd_reg   <= rd_byte;
            line_reg <= stat.launch ? line : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = ctrl_rd_reg ? ctrl_q : rd_reg;
    assign launch      = launch_reg;
    assign launch_seq  = launch_reg ? ctrl_q : 8'h00;
    assign launch_line = 4'(line_reg);
    assign bad_addr    = bad_reg;

endmodule

FILE: sv/wkup_checker.sv
// Port-level checker for wakeup_interrupt_unit, bound to the top level.
// Depends on wakeup_interrupt_unit_defines.svh.
`include "wakeup_interrupt_unit_defines.svh"

module wkup_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic        launch,
    input logic [7:0]  launch_seq,
    input logic [3:0]  launch_line,
    input logic        bad_addr
);

    `WKUP_ASSERT_IMP(a_idle_launch_zero, clk, rst_n, out_valid && !launch, launch_seq == 8'h00 && launch_line == 4'h0, "launch fields set without launch")
    `WKUP_ASSERT_IMP(a_bad_quiet, clk, rst_n, out_valid && bad_addr, !launch && read_data == 8'h00, "bad address request gave data or launch")
    `WKUP_ASSERT_IMP(a_read_no_launch, clk, rst_n, out_valid && read_data != 8'h00, !launch && !bad_addr, "read request gave a launch")
    `WKUP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(launch) && $stable(launch_seq) && $stable(launch_line), "result changed while stalled")

endmodule

bind wakeup_interrupt_unit wkup_checker u_wkup_checker (.*);

FILE: tb/tb_wakeup_interrupt_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for wakeup_interrupt_unit: register access, edge capture,
// priority launch and back-pressure, checked against an in-bench predictor.
// Depends on wkup_pkg and the wakeup_interrupt_unit RTL.
module tb_wakeup_interrupt_unit
    import wkup_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int MASK_BASE   = 0;
    localparam int FLAG_BASE   = FLAG_BYTES_DEF;
    localparam int CTRL_BASE   = 2 * FLAG_BYTES_DEF;
    localparam int REG_END     = CTRL_BASE + NUM_LINES_DEF;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  addr;
        logic [7:0]  wdata;
        logic [15:0] levels;
        logic        busy;
    } wkup_req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       launch;
        logic [7:0] seq;
        logic [3:0] line;
        logic       bad;
    } wkup_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [4:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] irq_levels;
    logic        seq_busy;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        launch;
    logic [7:0]  launch_seq;
    logic [3:0]  launch_line;
    logic        bad_addr;

    // predictor state
    logic [15:0]      lvl_hist;
    logic [1:0][7:0]  pend_flags;
    logic [1:0][7:0]  line_masks;
    logic [7:0]       seq_ctrl [NUM_LINES_DEF];

    wkup_res_t expected_q [$];
    int        err_cnt     = 0;
    int        cycle_cnt   = 0;
    int        hold_cnt    = 0;
    int        rx_stall    = 0;
    bit        tx_idle_en  = 1'b1;
    bit        rx_idle_en  = 1'b1;
    logic [15:0] stim_lv   = '0;

    wakeup_interrupt_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .irq_levels  (irq_levels),
        .seq_busy    (seq_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .launch      (launch),
        .launch_seq  (launch_seq),
        .launch_line (launch_line),
        .bad_addr    (bad_addr)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_predictor();
        lvl_hist      = '0;
        pend_flags    = '0;
        line_masks[0] = MASK_RST_DEF;
        line_masks[1] = MASK_RST_B1;
        foreach (seq_ctrl[i])
            seq_ctrl[i] = '0;
    endtask

    function automatic wkup_res_t predict_wakeup(input wkup_req_t r);
        wkup_res_t   res;
        logic        scan;
        logic [15:0] rise;
        logic [15:0] live;
        res  = '0;
        scan = 1'b0;
        if (r.action == ACT_READ || r.action == ACT_WRITE)
        begin
            if (r.addr >= REG_END)
                res.bad = 1'b1;
            else if (r.action == ACT_READ)
            begin
                if (r.addr < FLAG_BASE)
                    res.rdata = line_masks[r.addr - MASK_BASE];
                else if (r.addr < CTRL_BASE)
                    res.rdata = pend_flags[r.addr - FLAG_BASE];
                else
                    res.rdata = seq_ctrl[r.addr - CTRL_BASE];
            end
            else
            begin
                if (r.addr < FLAG_BASE)
                    line_masks[r.addr - MASK_BASE] = r.wdata;
                else if (r.addr < CTRL_BASE)
                    pend_flags[r.addr - FLAG_BASE] = r.wdata;
                else
                    seq_ctrl[r.addr - CTRL_BASE] = r.wdata;
                scan = 1'b1;
            end
        end
        else if (r.action == ACT_SAMPLE)
        begin
            rise       = r.levels & ~lvl_hist;
            lvl_hist   = r.levels;
            pend_flags = pend_flags | rise;
            scan       = 1'b1;
        end
        if (scan && !r.busy)
        begin
            live = pend_flags & ~line_masks;
            // lowest line wins
            for (int i = NUM_LINES_DEF - 1; i >= 0; i--)
            begin
                if (live[i])
                begin
                    res.launch = 1'b1;
                    res.line   = 4'(i);
                    res.seq    = seq_ctrl[i];
                end
            end
        end
        return res;
    endfunction

    function automatic wkup_req_t mk_req(input logic [1:0] act, input logic [4:0] addr,
                                          input logic [7:0] wdata, input logic [15:0] lv,
                                          input logic busy);
        wkup_req_t r;
        r.action = act;
        r.addr   = addr;
        r.wdata  = wdata;
        r.levels = lv;
        r.busy   = busy;
        return r;
    endfunction

    function automatic wkup_req_t rand_request();
        wkup_req_t r;
        int        p;
        p = $urandom_range(0, 99);
        if (p < 40)
            r.action = ACT_SAMPLE;
        else if (p < 70)
            r.action = ACT_WRITE;
        else if (p < 95)
            r.action = ACT_READ;
        else
            r.action = ACT_NONE;
        if ($urandom_range(0, 99) < 88)
            r.addr = 5'($urandom_range(0, REG_END - 1));
        else
            r.addr = 5'($urandom_range(REG_END, 31));
        r.wdata = 8'($urandom_range(0, 255));
        p = $urandom_range(0, 99);
        if (p < 45)
            stim_lv = 16'($urandom_range(0, 65535));
        else if (p < 90)
            stim_lv = stim_lv ^ (16'd1 << $urandom_range(0, 15));
        else
            stim_lv = '0;
        r.levels = stim_lv;
        r.busy   = ($urandom_range(0, 99) < 25);
        return r;
    endfunction

    task automatic send_request(input wkup_req_t r);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= r.action;
        reg_addr   <= r.addr;
        write_data <= r.wdata;
        irq_levels <= r.levels;
        seq_busy   <= r.busy;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(predict_wakeup(r));
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // response side: a long hold-off when the back-pressure test sets one, else random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                out_ready <= 1'b0;
                hold_cnt--;
            end
            else if (rx_stall > 0)
            begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 99) < 25)
                    rx_stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        wkup_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request outstanding", 1, 0);
            else
            begin
                want = expected_q.pop_front();
                if (read_data !== want.rdata)
                    report_mismatch("read_data", read_data, want.rdata);
                if (launch !== want.launch)
                    report_mismatch("launch", launch, want.launch);
                if (launch_seq !== want.seq)
                    report_mismatch("launch_seq", launch_seq, want.seq);
                if (launch_line !== want.line)
                    report_mismatch("launch_line", launch_line, want.line);
                if (bad_addr !== want.bad)
                    report_mismatch("bad_addr", bad_addr, want.bad);
            end
        end
    end

    task automatic test_reset_values();
        send_request(mk_req(ACT_READ, 5'(MASK_BASE), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(MASK_BASE + 1), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(FLAG_BASE), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(FLAG_BASE + 1), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(CTRL_BASE), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(REG_END - 1), 8'h00, 16'h0000, 1'b0));
    endtask

    task automatic test_bad_address();
        send_request(mk_req(ACT_READ, 5'(REG_END), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'd31, 8'hFF, 16'hFFFF, 1'b1));
        send_request(mk_req(ACT_WRITE, 5'd31, 8'hFF, 16'h0000, 1'b0));
        send_request(mk_req(ACT_WRITE, 5'(REG_END), 8'h00, 16'h0000, 1'b0));
    endtask

    task automatic test_edge_launch();
        send_request(mk_req(ACT_WRITE, 5'(CTRL_BASE), 8'hA5, 16'h0000, 1'b0));
        send_request(mk_req(ACT_WRITE, 5'(REG_END - 1), 8'hFF, 16'h0000, 1'b0));
        send_request(mk_req(ACT_WRITE, 5'(MASK_BASE), 8'h00, 16'h0000, 1'b0));
        // edges while the sequencer is busy: flagged, no launch
        send_request(mk_req(ACT_SAMPLE, 5'd0, 8'h00, 16'hFFFF, 1'b1));
        send_request(mk_req(ACT_SAMPLE, 5'd0, 8'h00, 16'hFFFF, 1'b0));
    endtask

    task automatic test_priority_mask();
        send_request(mk_req(ACT_WRITE, 5'(FLAG_BASE), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_WRITE, 5'(MASK_BASE + 1), 8'h7F, 16'h0000, 1'b0));
        send_request(mk_req(ACT_WRITE, 5'(FLAG_BASE + 1), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_READ, 5'(FLAG_BASE + 1), 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_SAMPLE, 5'd0, 8'h00, 16'h0000, 1'b0));
        send_request(mk_req(ACT_SAMPLE, 5'd0, 8'h00, 16'h8001, 1'b0));
    endtask

    task automatic test_unused_action();
        send_request(mk_req(ACT_NONE, 5'd31, 8'hFF, 16'hFFFF, 1'b1));
        send_request(mk_req(ACT_NONE, 5'd0, 8'h00, 16'h0000, 1'b0));
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_request(rand_request());
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n) send_request(rand_request());
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure(input int n);
        tx_idle_en = 1'b0;
        hold_cnt   = 300;
        repeat (n) send_request(rand_request());
        tx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_READ;
        reg_addr   = '0;
        write_data = '0;
        irq_levels = '0;
        seq_busy   = 1'b0;
        clear_predictor();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_bad_address();
        test_edge_launch();
        test_priority_mask();
        test_unused_action();
        drain_results();
        test_random_traffic(600);
        drain_results();
        test_back_to_back(100);
        drain_results();
        test_backpressure(150);
        drain_results();

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: wakeup_interrupt_unit.f
+incdir+sv
sv/wkup_pkg.sv
sv/wkup_ram.sv
sv/wkup_ctrl_store.sv
sv/wkup_state.sv
sv/wakeup_interrupt_unit.sv
sv/wkup_checker.sv
tb/tb_wakeup_interrupt_unit.sv
